// ----- rtl/integer_to_radix_digits_macros.svh -----
// assertion macros for the integer_to_radix_digits checker
// no dependencies; taken in by the checker file
`ifndef INTEGER_TO_RADIX_DIGITS_MACROS_SVH
`define INTEGER_TO_RADIX_DIGITS_MACROS_SVH

// condition holds in the same cycle
`define ITRD_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("itrd check failed");

// condition holds in the following cycle
`define ITRD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("itrd check failed");

`endif

// ----- rtl/itrd_pkg.sv -----
// shared constants, types and the digit character lookup
// no dependencies
`default_nettype none

package itrd_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int MAX_RADIX_DEF   = 16;

  localparam int RADIX_W = 5;
  localparam int DIGIT_W = 4;
  localparam int CHAR_W  = 8;
  localparam int DATA_W  = 32;
  localparam int INDEX_W = 3;

  localparam logic [INDEX_W-1:0] REG_RADIX       = 3'd0;
  localparam logic [INDEX_W-1:0] REG_CHARS_0_3   = 3'd1;
  localparam logic [INDEX_W-1:0] REG_CHARS_4_7   = 3'd2;
  localparam logic [INDEX_W-1:0] REG_CHARS_8_11  = 3'd3;
  localparam logic [INDEX_W-1:0] REG_CHARS_12_15 = 3'd4;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;

  localparam logic [DATA_W-1:0] CHARS_RESET_0_3   = 32'h3332_3130;
  localparam logic [DATA_W-1:0] CHARS_RESET_4_7   = 32'h3736_3534;
  localparam logic [DATA_W-1:0] CHARS_RESET_8_11  = 32'h4241_3938;
  localparam logic [DATA_W-1:0] CHARS_RESET_12_15 = 32'h4645_4443;

  localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'h2D;

  typedef logic [3:0][DATA_W-1:0] char_table_t;

  typedef struct packed {
    logic done;
    logic nonzero;
  } div_status_t;

  function automatic logic [CHAR_W-1:0] digit_char(input char_table_t tbl,
                                                   input logic [DIGIT_W-1:0] d);
    logic [DATA_W-1:0] word;
    word = tbl[d[3:2]];
    digit_char = word[{d[1:0], 3'b000} +: CHAR_W];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/itrd_divider.sv -----
// bit-serial restoring divider: one quotient bit per cycle, small remainder
// depends on itrd_pkg
`default_nettype none

module itrd_divider import itrd_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   load,
  input  wire logic [VALUE_WIDTH-1:0] dividend,
  input  wire logic [RADIX_W-1:0]     divisor,
  output logic      [VALUE_WIDTH-1:0] quotient,
  output logic      [DIGIT_W-1:0]     remainder,
  output div_status_t                 status
);

  localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

  logic                 run;
  logic                 done;
  logic                 nonzero;
  logic [CNT_W-1:0]     bitcnt;
  logic [RADIX_W-1:0]   dvs;
  logic [RADIX_W-1:0]   trial;
  logic [RADIX_W-1:0]   diff;
  logic                 ge;
  logic [DIGIT_W-1:0]   remainder_next;

  assign trial          = {remainder, quotient[VALUE_WIDTH-1]};
  assign ge             = (trial >= dvs);
  assign diff           = trial - dvs;
  assign remainder_next = ge ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];

  assign status.done    = done;
  assign status.nonzero = nonzero;

  always_ff @(posedge clk) begin
    if (rst) begin
      run    <= 1'b0;
      done   <= 1'b0;
      bitcnt <= '0;
    end else begin
      done <= 1'b0;
      if (load) begin
        run    <= 1'b1;
        bitcnt <= CNT_W'(VALUE_WIDTH);
      end else if (run) begin
        bitcnt <= bitcnt - 1'b1;
        if (bitcnt == CNT_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: shift the dividend out, quotient bits in
  always_ff @(posedge clk) begin
    if (load) begin
      quotient  <= dividend;
      remainder <= '0;
      dvs       <= divisor;
      nonzero   <= 1'b0;
    end else if (run) begin
      quotient  <= {quotient[VALUE_WIDTH-2:0], ge};
      remainder <= remainder_next;
      if (ge) begin
        nonzero <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/integer_to_radix_digits.sv -----
// top level: signed integer to text characters in a configurable radix
// depends on itrd_pkg and itrd_divider
//
// usage
//   a value is taken at a clock edge where start is high and busy is low.
//   its text comes out one character per transfer on char_code, each shown
//   for one cycle with strobe high; last marks the final character. a minus
//   character leads for negative values, then digits most significant first.
//   wr_en, wr_index and wr_data write the radix and the digit character
//   table; write only while busy is low.
// timing
//   each digit takes one full pass of the bit-serial divider, which sets
//   the rate. the minus character appears the cycle after the final
//   division, then each digit character follows a fetch state (digit memory
//   read) and an emit state.
//   busy falls in the cycle where the last character is shown, so a new
//   value may be taken then.
// reset
//   rst clears the sequencer and returns radix 10 and digits "0".."F".
//   the receiver cannot stall: every strobe is a transfer.
`default_nettype none

module integer_to_radix_digits import itrd_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int MAX_RADIX   = MAX_RADIX_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic signed [VALUE_WIDTH-1:0] value,
  input  wire logic                          wr_en,
  input  wire logic        [INDEX_W-1:0]     wr_index,
  input  wire logic        [DATA_W-1:0]      wr_data,
  output logic                               strobe,
  output logic             [CHAR_W-1:0]      char_code,
  output logic                               last
);

  localparam int AW = $clog2(VALUE_WIDTH);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_DIV   = 2'd1;
  localparam logic [1:0] ST_FETCH = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0]              state;
  logic [RADIX_W-1:0]      radix;
  char_table_t             chars;
  logic                    negative;
  logic [AW-1:0]           cnt;
  logic [AW-1:0]           rd_addr;
  logic [DIGIT_W-1:0]      rd_data;
  logic [DIGIT_W-1:0]      mem [VALUE_WIDTH];

  logic [VALUE_WIDTH-1:0]  value_u;
  logic [VALUE_WIDTH-1:0]  mag;
  logic [RADIX_W-1:0]      radix_eff;
  logic                    accept;
  logic                    div_load;
  logic [VALUE_WIDTH-1:0]  dividend;
  logic [VALUE_WIDTH-1:0]  quotient;
  logic [DIGIT_W-1:0]      remainder;
  div_status_t             div_st;
  logic                    digit_done;

  assign value_u    = value;
  assign mag        = value_u[VALUE_WIDTH-1]
                      ? (~value_u + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : value_u;
  assign busy       = (state != ST_IDLE);
  assign accept     = start && (state == ST_IDLE);
  assign digit_done = (state == ST_DIV) && div_st.done;
  assign div_load   = accept || (digit_done && div_st.nonzero);
  assign dividend   = (state == ST_IDLE) ? mag : quotient;

  always_comb begin
    if (radix < RADIX_MIN) begin
      radix_eff = RADIX_MIN;
    end else if (radix > RADIX_W'(MAX_RADIX)) begin
      radix_eff = RADIX_W'(MAX_RADIX);
    end else begin
      radix_eff = radix;
    end
  end

  itrd_divider #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_divider (
    .clk       (clk),
    .rst       (rst),
    .load      (div_load),
    .dividend  (dividend),
    .divisor   (radix_eff),
    .quotient  (quotient),
    .remainder (remainder),
    .status    (div_st)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      radix    <= RADIX_RESET;
      chars[0] <= CHARS_RESET_0_3;
      chars[1] <= CHARS_RESET_4_7;
      chars[2] <= CHARS_RESET_8_11;
      chars[3] <= CHARS_RESET_12_15;
    end else if (wr_en) begin
      case (wr_index)
        REG_RADIX:       radix    <= wr_data[RADIX_W-1:0];
        REG_CHARS_0_3:   chars[0] <= wr_data;
        REG_CHARS_4_7:   chars[1] <= wr_data;
        REG_CHARS_8_11:  chars[2] <= wr_data;
        REG_CHARS_12_15: chars[3] <= wr_data;
        default: ;
      endcase
    end
  end

  // digit store, least significant digit at address zero
  always_ff @(posedge clk) begin
    if (digit_done) begin
      mem[cnt] <= remainder;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      strobe    <= 1'b0;
      char_code <= '0;
      last      <= 1'b0;
      negative  <= 1'b0;
      cnt       <= '0;
      rd_addr   <= '0;
    end else begin
      strobe <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            state    <= ST_DIV;
            cnt      <= '0;
            negative <= value_u[VALUE_WIDTH-1];
          end
        end
        ST_DIV: begin
          if (div_st.done) begin
            if (div_st.nonzero) begin
              cnt <= cnt + 1'b1;
            end else begin
              rd_addr <= cnt;
              state   <= ST_FETCH;
              if (negative) begin
                strobe    <= 1'b1;
                char_code <= MINUS_CHAR;
                last      <= 1'b0;
              end
            end
          end
        end
        ST_FETCH: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          strobe    <= 1'b1;
          char_code <= digit_char(chars, rd_data);
          last      <= (rd_addr == '0);
          if (rd_addr == '0) begin
            state <= ST_IDLE;
          end else begin
            rd_addr <= rd_addr - 1'b1;
            state   <= ST_FETCH;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/itrd_checker.sv -----
// port-level checks for integer_to_radix_digits, bound to the top level
// depends on integer_to_radix_digits_macros.svh
`default_nettype none

`include "integer_to_radix_digits_macros.svh"

module itrd_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic strobe,
  input wire logic last
);

  // an accepted value keeps the block busy
  `ITRD_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)

  // characters never come in adjacent cycles
  `ITRD_ASSERT_NEXT(a_strobe_gap, clk, rst, strobe, !strobe)

  // more characters to come means the block is still working
  `ITRD_ASSERT_SAME(a_more_busy, clk, rst, strobe && !last, busy)

  // a character shown while idle ends the text
  `ITRD_ASSERT_SAME(a_idle_last, clk, rst, strobe && !busy, last)

endmodule

bind integer_to_radix_digits itrd_checker u_itrd_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .strobe (strobe),
  .last   (last)
);

`default_nettype wire

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// testbench for integer_to_radix_digits: directed table then random values,
// every character checked against the table text or an in-bench text predictor
// depends on itrd_pkg and the integer_to_radix_digits rtl
module testbench;
  import itrd_pkg::*;

  localparam int BLOCKS          = 6;
  localparam int ITEMS_PER_BLOCK = 16;
  localparam int CYCLE_LIMIT     = 2_000_000;

  localparam logic [INDEX_W-1:0] REG_SPARE_FIRST = 3'd5;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              tail;
  } char_t;

  typedef enum logic {ROW_WRITE, ROW_VALUE} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    logic [INDEX_W-1:0] index;
    logic [DATA_W-1:0]  data;
    string              text;
  } row_t;

  logic                     clk;
  logic                     rst      = 1'b1;
  logic                     start    = 1'b0;
  logic signed [DATA_W-1:0] value    = '0;
  logic                     wr_en    = 1'b0;
  logic [INDEX_W-1:0]       wr_index = '0;
  logic [DATA_W-1:0]        wr_data  = '0;
  logic                     busy;
  logic                     strobe;
  logic [CHAR_W-1:0]        char_code;
  logic                     last;

  logic [RADIX_W-1:0] cfg_radix = RADIX_RESET;
  char_table_t        cfg_chars = {CHARS_RESET_12_15, CHARS_RESET_8_11,
                                   CHARS_RESET_4_7, CHARS_RESET_0_3};

  char_t pending_chars [$];
  int    errors     = 0;
  int    items_sent = 0;
  int    cycles     = 0;

  // directed stimulus; text left empty means the predictor supplies it
  row_t plan [$] = '{
    '{ROW_VALUE, '0, 32'h0000_0000, "0"},
    '{ROW_VALUE, '0, 32'h0000_0001, "1"},
    '{ROW_VALUE, '0, 32'hFFFF_FFFF, "-1"},
    '{ROW_VALUE, '0, 32'h7FFF_FFFF, "2147483647"},
    '{ROW_VALUE, '0, 32'h8000_0000, "-2147483648"},
    '{ROW_VALUE, '0, 32'hFFFF_FFF6, "-10"},
    '{ROW_WRITE, REG_RADIX, 32'd16, ""},
    '{ROW_VALUE, '0, 32'h7FFF_FFFF, "7FFFFFFF"},
    '{ROW_VALUE, '0, 32'h8000_0000, "-80000000"},
    '{ROW_VALUE, '0, 32'h00AB_CDEF, "ABCDEF"},
    '{ROW_WRITE, REG_RADIX, 32'hFFFF_FFE2, ""},
    '{ROW_VALUE, '0, 32'h8000_0000, ""},
    '{ROW_VALUE, '0, 32'h7FFF_FFFF, ""},
    '{ROW_VALUE, '0, 32'h0000_0005, "101"},
    '{ROW_WRITE, REG_RADIX, 32'd0, ""},
    '{ROW_VALUE, '0, 32'hFFFF_FFFA, "-110"},
    '{ROW_WRITE, REG_RADIX, 32'd1, ""},
    '{ROW_VALUE, '0, 32'h0000_0003, "11"},
    '{ROW_WRITE, REG_RADIX, 32'd31, ""},
    '{ROW_VALUE, '0, 32'h0000_00FF, "FF"},
    '{ROW_WRITE, REG_RADIX, 32'd17, ""},
    '{ROW_VALUE, '0, 32'hFFFF_FF00, "-100"},
    '{ROW_WRITE, REG_SPARE_FIRST, 32'd3, ""},
    '{ROW_VALUE, '0, 32'h0000_0FFF, "FFF"},
    '{ROW_WRITE, REG_CHARS_0_3, 32'h0000_FF00, ""},
    '{ROW_WRITE, REG_CHARS_12_15, 32'h8081_7F2D, ""},
    '{ROW_VALUE, '0, 32'h0000_1F0D, ""},
    '{ROW_WRITE, REG_CHARS_4_7, 32'hA5C3_0F01, ""},
    '{ROW_WRITE, REG_CHARS_8_11, 32'hFE80_7F20, ""},
    '{ROW_VALUE, '0, 32'h0000_0000, ""},
    '{ROW_VALUE, '0, 32'h89AB_4567, ""},
    '{ROW_WRITE, REG_RADIX, 32'd3, ""},
    '{ROW_VALUE, '0, 32'h8000_0000, ""},
    '{ROW_WRITE, REG_RADIX, 32'd7, ""},
    '{ROW_VALUE, '0, 32'h7FFF_FFFF, ""}
  };

  integer_to_radix_digits i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .value     (value),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data),
    .strobe    (strobe),
    .char_code (char_code),
    .last      (last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic note_failure(input string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endtask

  always @(posedge clk) begin
    char_t want;
    if (!rst && strobe === 1'b1) begin
      if (pending_chars.size() == 0) begin
        note_failure($sformatf("character %h with none outstanding", char_code));
      end else begin
        want = pending_chars.pop_front();
        if (char_code !== want.code)
          note_failure($sformatf("char_code: expected %h, got %h", want.code, char_code));
        if (last !== want.tail)
          note_failure($sformatf("last: expected %b, got %b (char %h)",
                                 want.tail, last, want.code));
      end
    end
  end

  function automatic int effective_base();
    int base;
    base = int'(cfg_radix);
    if (base < int'(RADIX_MIN)) base = int'(RADIX_MIN);
    if (base > MAX_RADIX_DEF) base = MAX_RADIX_DEF;
    return base;
  endfunction

  // text of one value under the current radix and digit table
  function automatic void render_value(input logic [DATA_W-1:0] v);
    logic [DATA_W-1:0]  mag;
    logic [DATA_W-1:0]  base;
    logic [DATA_W-1:0]  word;
    logic [DIGIT_W-1:0] digits [$];
    base = DATA_W'(effective_base());
    mag  = v[DATA_W-1] ? -v : v;
    do begin
      digits.push_front(DIGIT_W'(mag % base));
      mag = mag / base;
    end while (mag != 0);
    if (v[DATA_W-1]) pending_chars.push_back('{MINUS_CHAR, 1'b0});
    foreach (digits[k]) begin
      word = cfg_chars[digits[k][3:2]];
      pending_chars.push_back('{word[8 * digits[k][1:0] +: CHAR_W], k == digits.size() - 1});
    end
  endfunction

  function automatic logic [DATA_W-1:0] random_value();
    logic [DATA_W-1:0] v;
    int base;
    int k;
    case ($urandom_range(0, 5))
      0: v = $urandom();
      1: v = $urandom_range(0, 40);
      2: v = -$urandom_range(1, 40);
      3: begin
        case ($urandom_range(0, 3))
          0: v = 32'h8000_0000;
          1: v = 32'h7FFF_FFFF;
          2: v = '0;
          default: v = '1;
        endcase
      end
      4: begin
        // powers of the base and their neighbours
        base = effective_base();
        v = 1;
        k = $urandom_range(1, 31);
        repeat (k) if (v <= 32'h7FFF_FFFF / base) v = v * base;
        v = v + $urandom_range(0, 2) - 1;
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      default: begin
        v = $urandom() >> $urandom_range(0, 31);
        if ($urandom_range(0, 1) == 1) v = -v;
      end
    endcase
    return v;
  endfunction

  function automatic int idle_pct();
    if (items_sent < 40) return 19;
    if (items_sent < 80) return 62;
    return 0;
  endfunction

  task automatic send_value(input logic [DATA_W-1:0] v, input string text);
    int gap;
    if ($urandom_range(1, 100) <= idle_pct()) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 1200) : $urandom_range(1, 6);
      if (start === 1'b1) start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    value <= v;
    do @(posedge clk); while (busy !== 1'b0);
    if (text.len() == 0) begin
      render_value(v);
    end else begin
      for (int i = 0; i < text.len(); i++)
        pending_chars.push_back('{text[i], i == text.len() - 1});
    end
    items_sent++;
  endtask

  // wait for every outstanding character and an idle block
  task automatic settle();
    if (start === 1'b1) start <= 1'b0;
    while (pending_chars.size() != 0 || busy !== 1'b0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [INDEX_W-1:0] index, input logic [DATA_W-1:0] data);
    @(posedge clk);
    wr_en    <= 1'b1;
    wr_index <= index;
    wr_data  <= data;
    @(posedge clk);
    wr_en <= 1'b0;
    case (index)
      REG_RADIX:       cfg_radix    = data[RADIX_W-1:0];
      REG_CHARS_0_3:   cfg_chars[0] = data;
      REG_CHARS_4_7:   cfg_chars[1] = data;
      REG_CHARS_8_11:  cfg_chars[2] = data;
      REG_CHARS_12_15: cfg_chars[3] = data;
      default: ;
    endcase
  endtask

  initial begin
    logic [DATA_W-1:0] radix_word;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        settle();
        write_reg(plan[i].index, plan[i].data);
      end else begin
        send_value(plan[i].data, plan[i].text);
      end
    end

    for (int b = 0; b < BLOCKS; b++) begin
      settle();
      radix_word = $urandom();
      case (b)
        0: radix_word[RADIX_W-1:0] = RADIX_MIN;
        1: radix_word[RADIX_W-1:0] = RADIX_W'(MAX_RADIX_DEF);
        2: radix_word[RADIX_W-1:0] = '0;
        3: radix_word[RADIX_W-1:0] = '1;
        default: ;
      endcase
      write_reg(REG_RADIX, radix_word);
      write_reg(REG_CHARS_0_3, (b < 2) ? CHARS_RESET_0_3 : $urandom());
      write_reg(REG_CHARS_4_7, (b < 2) ? CHARS_RESET_4_7 : $urandom());
      write_reg(REG_CHARS_8_11, (b < 2) ? CHARS_RESET_8_11 : $urandom());
      write_reg(REG_CHARS_12_15, (b < 2) ? CHARS_RESET_12_15 : $urandom());
      write_reg(INDEX_W'(REG_SPARE_FIRST + $urandom_range(0, 2)), $urandom());
      for (int n = 0; n < ITEMS_PER_BLOCK; n++) send_value(random_value(), "");
    end

    settle();
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
